[rtl/qau_pkg.sv]
// Package: shared types, constants and a saturation helper function for the quaternion unit.
package qau_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL    = 3'd2,
      OP_SCALE  = 3'd3,
      OP_CONJ   = 3'd4,
      OP_ROTATE = 3'd5,
      OP_MATRIX = 3'd6,
      OP_NONE   = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] a_w;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_w;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r0;
      logic signed [31:0] r1;
      logic signed [31:0] r2;
      logic signed [31:0] r3;
      logic               last;
   } rsp_type;

   // Saturate a wide signed sum to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

[rtl/quaternion_arith_unit_core.sv]
// Top level: pipelined quaternion arithmetic unit in signed fixed point.
// A request is accepted on any cycle in which req_stall is low, and its first result is
// presented once it has passed a multiply stage and a sum stage for the
// first Hamilton product, then the same again for the second, which rotation needs; the
// other operations are delayed to the same depth. Results wait in an eight-entry output
// queue, and req_stall rises while queued entries plus requests in flight reach eight, so
// one request enters per cycle as long as results are taken. A rotation-matrix request
// produces three result beats, so a run of them enters no faster than their beats are taken.
module quaternion_arith_unit_core #(
   parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qau_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qau_pkg::rsp_type  rsp_data
);
   import qau_pkg::*;

   localparam int Depth = 8;
   localparam int PtrW = $clog2(Depth);

   typedef struct packed {
      logic signed [31:0] c0;
      logic signed [31:0] c1;
      logic signed [31:0] c2;
      logic signed [31:0] c3;
      logic signed [31:0] c4;
      logic signed [31:0] c5;
      logic signed [31:0] c6;
      logic signed [31:0] c7;
      logic signed [31:0] c8;
      logic               is_mat;
   } res_type;

   logic        adv;
   logic [3:0]  vld_ff;
   op_type      op_ff [4];
   logic signed [32:0] ha [4], hb [4], h2b [4];
   logic signed [31:0] t [4], r [4];
   logic signed [32:0] c_ff [2][4];
   logic signed [32:0] c2 [4];
   logic signed [32:0] h2a [4];
   logic signed [31:0] simple_ff [4][4];
   logic signed [31:0] simple_in [4];
   logic signed [63:0] sq [4][4];
   logic signed [63:0] h2_prod [4][4];
   logic signed [31:0] m_ff [9];
   logic signed [31:0] scl_ff [4];
   logic signed [31:0] m_dly_ff [2][9];
   logic signed [31:0] scl_dly_ff [2][4];
   logic signed [31:0] t_dly_ff [2][4];
   res_type     res_in;
   res_type     q_ff [Depth];
   logic [PtrW:0]   cnt_ff;
   logic [PtrW-1:0] wp_ff, rp_ff;
   logic [1:0]  col_ff;
   logic        push, pop;
   logic signed [32:0] aw, ax, ay, az;

   // Queue count plus in-flight items must never exceed the queue depth.
   logic [4:0] used;
   assign used = 5'(cnt_ff) + 5'(vld_ff[0]) + 5'(vld_ff[1]) + 5'(vld_ff[2])
                 + 5'(vld_ff[3]);
   assign adv = 1'b1;
   assign req_stall = used >= 5'(Depth);

   assign aw = 33'(req_data.a_w);
   assign ax = 33'(req_data.a_x);
   assign ay = 33'(req_data.a_y);
   assign az = 33'(req_data.a_z);

   always_comb begin
      ha[0] = aw; ha[1] = ax; ha[2] = ay; ha[3] = az;
      hb[0] = (op_type'(req_data.op) == OP_ROTATE) ? 33'sd0 : 33'(req_data.b_w);
      hb[1] = 33'(req_data.b_x);
      hb[2] = 33'(req_data.b_y);
      hb[3] = 33'(req_data.b_z);
      if (op_type'(req_data.op) == OP_MATRIX) begin
         hb = ha;
      end
   end

   // Products for the matrix and for scaling come from the first unit's multiplier array.
   qau_hamilton #(.FRAC_BITS(FRAC_BITS)) u_h1 (
      .clock(clock), .en(adv), .a(ha), .b(hb), .r(t), .prod(sq)
   );

   // Conjugate of A travels alongside the first product.
   always_ff @(posedge clock) begin
      c_ff[0][0] <= aw;
      c_ff[0][1] <= -ax;
      c_ff[0][2] <= -ay;
      c_ff[0][3] <= -az;
      c_ff[1] <= c_ff[0];
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         h2a[k] = 33'(t[k]);
         c2[k] = c_ff[1][k];
      end
      h2b = c2;
   end

   qau_hamilton #(.FRAC_BITS(FRAC_BITS)) u_h2 (
      .clock(clock), .en(adv), .a(h2a), .b(h2b), .r(r), .prod(h2_prod)
   );

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         simple_in[k] = 32'sd0;
      end
      unique case (op_type'(req_data.op))
         OP_ADD: begin
            simple_in[0] = sat32(64'(req_data.a_w) + 64'(req_data.b_w));
            simple_in[1] = sat32(64'(req_data.a_x) + 64'(req_data.b_x));
            simple_in[2] = sat32(64'(req_data.a_y) + 64'(req_data.b_y));
            simple_in[3] = sat32(64'(req_data.a_z) + 64'(req_data.b_z));
         end
         OP_SUB: begin
            simple_in[0] = sat32(64'(req_data.a_w) - 64'(req_data.b_w));
            simple_in[1] = sat32(64'(req_data.a_x) - 64'(req_data.b_x));
            simple_in[2] = sat32(64'(req_data.a_y) - 64'(req_data.b_y));
            simple_in[3] = sat32(64'(req_data.a_z) - 64'(req_data.b_z));
         end
         OP_CONJ: begin
            simple_in[0] = req_data.a_w;
            simple_in[1] = sat32(-64'(req_data.a_x));
            simple_in[2] = sat32(-64'(req_data.a_y));
            simple_in[3] = sat32(-64'(req_data.a_z));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      simple_ff[0] <= simple_in;
      simple_ff[1] <= simple_ff[0];
      simple_ff[2] <= simple_ff[1];
      simple_ff[3] <= simple_ff[2];
   end

   // Matrix entries, built from the registered product array (a_i*a_j).
   always_ff @(posedge clock) begin
      m_ff[0] <= sat32(sq[0][0] + sq[1][1] - sq[2][2] - sq[3][3]);
      m_ff[1] <= sat32(2 * sq[0][3] + 2 * sq[1][2]);
      m_ff[2] <= sat32(2 * sq[1][3] - 2 * sq[0][2]);
      m_ff[3] <= sat32(2 * sq[1][2] - 2 * sq[0][3]);
      m_ff[4] <= sat32(sq[0][0] - sq[1][1] + sq[2][2] - sq[3][3]);
      m_ff[5] <= sat32(2 * sq[0][1] + 2 * sq[2][3]);
      m_ff[6] <= sat32(2 * sq[0][2] + 2 * sq[1][3]);
      m_ff[7] <= sat32(2 * sq[2][3] - 2 * sq[0][1]);
      m_ff[8] <= sat32(sq[0][0] - sq[1][1] - sq[2][2] + sq[3][3]);
      for (int k = 0; k < 4; k++) begin
         scl_ff[k] <= sat32(sq[k][0]);
      end
   end

   // Stage bookkeeping: op and valid travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], req_valid & ~req_stall};
      end
      op_ff[0] <= op_type'(req_data.op);
      for (int k = 1; k < 4; k++) begin
         op_ff[k] <= op_ff[k-1];
      end
   end

   // Results land at stage 3 (second product registered). Other ops are delayed to match.
   always_ff @(posedge clock) begin
      m_dly_ff[0] <= m_ff;    m_dly_ff[1] <= m_dly_ff[0];
      scl_dly_ff[0] <= scl_ff; scl_dly_ff[1] <= scl_dly_ff[0];
      t_dly_ff[0] <= t;       t_dly_ff[1] <= t_dly_ff[0];
   end

   always_comb begin
      res_in = '0;
      unique case (op_ff[3])
         OP_ADD, OP_SUB, OP_CONJ: begin
            res_in.c0 = simple_ff[3][0]; res_in.c1 = simple_ff[3][1];
            res_in.c2 = simple_ff[3][2]; res_in.c3 = simple_ff[3][3];
         end
         OP_MUL: begin
            res_in.c0 = t_dly_ff[1][0]; res_in.c1 = t_dly_ff[1][1];
            res_in.c2 = t_dly_ff[1][2]; res_in.c3 = t_dly_ff[1][3];
         end
         OP_SCALE: begin
            res_in.c0 = scl_dly_ff[1][0]; res_in.c1 = scl_dly_ff[1][1];
            res_in.c2 = scl_dly_ff[1][2]; res_in.c3 = scl_dly_ff[1][3];
         end
         OP_ROTATE: begin
            res_in.c1 = r[1]; res_in.c2 = r[2]; res_in.c3 = r[3];
         end
         OP_MATRIX: begin
            res_in.c0 = m_dly_ff[1][0]; res_in.c1 = m_dly_ff[1][1];
            res_in.c2 = m_dly_ff[1][2]; res_in.c3 = m_dly_ff[1][3];
            res_in.c4 = m_dly_ff[1][4]; res_in.c5 = m_dly_ff[1][5];
            res_in.c6 = m_dly_ff[1][6]; res_in.c7 = m_dly_ff[1][7];
            res_in.c8 = m_dly_ff[1][8];
            res_in.is_mat = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Output queue; each entry stays until its last column is taken.
   assign push = vld_ff[3];
   assign pop  = rsp_valid & ~rsp_stall & rsp_data.last;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= '0;
         rp_ff  <= '0;
         col_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + PtrW'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + PtrW'(1);
            col_ff <= '0;
         end else if (rsp_valid & ~rsp_stall) begin
            col_ff <= col_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
      end
   end

   assign rsp_valid = cnt_ff != '0;

   always_comb begin
      res_type e;
      e = q_ff[rp_ff];
      rsp_data = '0;
      if (e.is_mat) begin
         rsp_data.last = col_ff == 2'd2;
         unique case (col_ff)
            2'd0: begin
               rsp_data.r0 = e.c0; rsp_data.r1 = e.c1; rsp_data.r2 = e.c2;
            end
            2'd1: begin
               rsp_data.r0 = e.c3; rsp_data.r1 = e.c4; rsp_data.r2 = e.c5;
            end
            default: begin
               rsp_data.r0 = e.c6; rsp_data.r1 = e.c7; rsp_data.r2 = e.c8;
            end
         endcase
      end else begin
         rsp_data.r0 = e.c0; rsp_data.r1 = e.c1;
         rsp_data.r2 = e.c2; rsp_data.r3 = e.c3;
         rsp_data.last = 1'b1;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      used <= 5'(Depth)) else $error("output queue overrun");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff < (PtrW+1)'(Depth) || pop) else $error("push into full queue");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff != 2'd3) else $error("column index out of range");
`endif
endmodule

[rtl/qau_fmul.sv]
// Module: registered 33x33 signed multiply with floor shift by the fraction width.
module qau_fmul #(
   parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [32:0]  a,
   input  logic signed [32:0]  b,
   output logic signed [63:0]  p
);
   import qau_pkg::*;

   logic signed [65:0] prod_in;
   logic signed [65:0] shifted;
   logic signed [63:0] p_ff;

   // Arithmetic shift floors, matching truncation toward minus infinity.
   assign prod_in = a * b;
   assign shifted = prod_in >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= shifted[63:0];
      end
   end

   assign p = p_ff;
endmodule

[rtl/qau_hamilton.sv]
// Module: two-stage Hamilton product (register after products, register after sums).
module qau_hamilton #(
   parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [32:0] a [4],
   input  logic signed [32:0] b [4],
   output logic signed [31:0] r [4],
   output logic signed [63:0] prod [4][4]
);
   import qau_pkg::*;

   logic signed [63:0] p [4][4];
   logic signed [31:0] r_ff [4];
   logic signed [63:0] s_in [4];

   for (genvar i = 0; i < 4; i++) begin : g_i
      for (genvar j = 0; j < 4; j++) begin : g_j
         qau_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
            .clock(clock), .en(en), .a(a[i]), .b(b[j]), .p(p[i][j])
         );
      end
   end

   always_comb begin
      s_in[0] = p[0][0] - p[1][1] - p[2][2] - p[3][3];
      s_in[1] = p[0][1] + p[1][0] + p[2][3] - p[3][2];
      s_in[2] = p[0][2] + p[2][0] + p[3][1] - p[1][3];
      s_in[3] = p[0][3] + p[3][0] + p[1][2] - p[2][1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            r_ff[k] <= sat32(s_in[k]);
         end
      end
   end

   assign r    = r_ff;
   assign prod = p;
endmodule
